[rtl/pft_pkg.sv]
// pft_pkg: types, constants and helpers for the packet flow tracker.
// Used by pft_front, pft_back and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pft_pkg;

    localparam int FLOW_ENTRIES_DEF = 256;

    localparam logic [15:0] ETH_IPV4       = 16'h0800;
    localparam logic [7:0]  PROTO_UDP      = 8'd17;
    localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
    localparam logic [7:0]  FLAGS_PURE_ACK = 8'h10;
    localparam logic [7:0]  SAMPLE_LIMIT_RST = 8'd100;

    localparam logic [15:0] PORT_HTTP      = 16'd80;
    localparam logic [15:0] PORT_HTTP_ALT1 = 16'd8080;
    localparam logic [15:0] PORT_HTTP_ALT2 = 16'd8000;
    localparam logic [15:0] PORT_HTTP_ALT3 = 16'd8079;
    localparam logic [15:0] PORT_MYSQL     = 16'd3306;
    localparam logic [15:0] PORT_MEMCACHED = 16'd11211;

    localparam logic [1:0] SVC_UNKNOWN   = 2'd0;
    localparam logic [1:0] SVC_HTTP      = 2'd1;
    localparam logic [1:0] SVC_MYSQL     = 2'd2;
    localparam logic [1:0] SVC_MEMCACHED = 2'd3;

    // classified packet, front to back
    typedef struct packed {
        logic        ipv4;
        logic [63:0] addr_key;
        logic [31:0] port_key;
        logic [7:0]  proto;
        logic [15:0] payload;
        logic        pure_ack;
        logic [47:0] time_us;
        logic        svc_on_src;
        logic [1:0]  svc;
    } t_item;

    // per-flow counters held in the state RAM
    typedef struct packed {
        logic [31:0] bytes;
        logic [7:0]  samples;
        logic        svc_on_src;
        logic [1:0]  svc;
        logic [15:0] acks;
        logic [47:0] first_ack;
        logic [47:0] last_ack;
    } t_flow_state;

    localparam int KEY_W = 64 + 32 + 8;

    function automatic logic is_http(input logic [15:0] port);
        return (port == PORT_HTTP) || (port == PORT_HTTP_ALT1) ||
               (port == PORT_HTTP_ALT2) || (port == PORT_HTTP_ALT3);
    endfunction

    // {on_source, service}; http before mysql before memcached, destination port before source port
    function automatic logic [2:0] classify(input logic [15:0] sp, input logic [15:0] dp);
        logic [2:0] res;
        res = {1'b0, SVC_UNKNOWN};
        if (is_http(dp))                res = {1'b0, SVC_HTTP};
        else if (is_http(sp))           res = {1'b1, SVC_HTTP};
        else if (dp == PORT_MYSQL)      res = {1'b0, SVC_MYSQL};
        else if (sp == PORT_MYSQL)      res = {1'b1, SVC_MYSQL};
        else if (dp == PORT_MEMCACHED)  res = {1'b0, SVC_MEMCACHED};
        else if (sp == PORT_MEMCACHED)  res = {1'b1, SVC_MEMCACHED};
        return res;
    endfunction

endpackage
`default_nettype wire

[rtl/pft_ram.sv]
// pft_ram: generic simple dual-port RAM, one write and one registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

[rtl/pft_front.sv]
// pft_front: accepts header beats, classifies them and holds them in a
// two-entry queue for the back end; also holds the sample limit register.
// Depends on pft_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pft_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    output logic               o_full,
    input  wire logic [15:0]   i_ether_type,
    input  wire logic [3:0]    i_ip_header_words,
    input  wire logic [15:0]   i_ip_total_length,
    input  wire logic [7:0]    i_ip_protocol,
    input  wire logic [31:0]   i_source_ip,
    input  wire logic [31:0]   i_dest_ip,
    input  wire logic [15:0]   i_source_port,
    input  wire logic [15:0]   i_dest_port,
    input  wire logic [3:0]    i_tcp_header_words,
    input  wire logic [7:0]    i_tcp_flags,
    input  wire logic [47:0]   i_time_us,
    input  wire logic          i_cfg_valid,
    output logic               o_cfg_ready,
    input  wire logic [7:0]    i_cfg_data,
    output logic [7:0]         o_sample_limit,
    output logic               o_q_valid,
    output pft_pkg::t_item     o_q_item,
    input  wire logic          i_q_pop
);
    import pft_pkg::*;

    t_item      n_item;
    t_item      r_q [2];
    logic       r_rd_ptr;
    logic       r_wr_ptr;
    logic [1:0] r_count;
    logic [7:0] r_sample_limit;
    logic       push_ok;
    logic [15:0] l4_len;
    logic [2:0]  svc;

    // classification of the incoming beat
    always_comb begin
        l4_len = (i_ip_protocol == PROTO_UDP) ? UDP_HDR_BYTES
                                              : {10'd0, i_tcp_header_words, 2'b00};
        svc = classify(i_source_port, i_dest_port);
        n_item.ipv4       = (i_ether_type == ETH_IPV4);
        n_item.addr_key   = {i_source_ip, i_dest_ip};
        n_item.port_key   = {i_source_port, i_dest_port};
        n_item.proto      = i_ip_protocol;
        n_item.payload    = i_ip_total_length - {10'd0, i_ip_header_words, 2'b00} - l4_len;
        n_item.pure_ack   = (i_ip_protocol != PROTO_UDP) && (i_tcp_flags == FLAGS_PURE_ACK);
        n_item.time_us    = i_time_us;
        n_item.svc_on_src = svc[2];
        n_item.svc        = svc[1:0];
    end

    assign push_ok = i_push && !o_full;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

    // queue pointers and config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr       <= 1'b0;
            r_wr_ptr       <= 1'b0;
            r_count        <= 2'd0;
            r_sample_limit <= SAMPLE_LIMIT_RST;
        end else begin
            if (push_ok) r_wr_ptr <= ~r_wr_ptr;
            if (i_q_pop) r_rd_ptr <= ~r_rd_ptr;
            r_count <= r_count + {1'b0, push_ok} - {1'b0, i_q_pop};
            if (i_cfg_valid) r_sample_limit <= i_cfg_data;
        end
    end

    assign o_full         = (r_count == 2'd2);
    assign o_q_valid      = (r_count != 2'd0);
    assign o_q_item       = r_q[r_rd_ptr];
    assign o_cfg_ready    = 1'b1;
    assign o_sample_limit = r_sample_limit;
endmodule
`default_nettype wire

[rtl/pft_back.sv]
// pft_back: flow table search and update, result register.
// Depends on pft_pkg and pft_ram.
`timescale 1ns / 1ps
`default_nettype none
module pft_back #(
    parameter int FLOW_ENTRIES = pft_pkg::FLOW_ENTRIES_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  pft_pkg::t_item     i_q_item,
    output logic               o_q_pop,
    input  wire logic [7:0]    i_sample_limit,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic               o_accepted,
    output logic [7:0]         o_flow_slot,
    output logic               o_new_flow,
    output logic               o_table_full,
    output logic [15:0]        o_payload_length,
    output logic [31:0]        o_byte_total,
    output logic [7:0]         o_samples_held,
    output logic [1:0]         o_service,
    output logic               o_service_on_source,
    output logic [15:0]        o_ack_count,
    output logic [47:0]        o_ack_span_us
);
    import pft_pkg::*;

    localparam int IW = $clog2(FLOW_ENTRIES);
    localparam logic [IW:0] USED_MAX = (IW+1)'(FLOW_ENTRIES);
    localparam int SW = $bits(t_flow_state);

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_READ, S_UPD} t_state;

    t_state      r_state, n_state;
    logic [IW:0] r_rd_idx, n_rd_idx;
    logic        r_chk_valid, n_chk_valid;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic [IW-1:0] r_slot, n_slot;
    logic        r_new, n_new;
    logic        r_full, n_full;
    logic [IW:0] r_used, n_used;

    logic        r_out_valid, n_out_valid;
    logic        r_accepted, n_accepted;
    logic [7:0]  r_flow_slot, n_flow_slot;
    logic        r_new_flow, n_new_flow;
    logic        r_table_full, n_table_full;
    logic [15:0] r_payload, n_payload;
    logic [31:0] r_bytes, n_bytes;
    logic [7:0]  r_samples, n_samples;
    logic [1:0]  r_svc, n_svc;
    logic        r_svc_src, n_svc_src;
    logic [15:0] r_acks, n_acks;
    logic [47:0] r_span, n_span;

    logic              out_free;
    logic              key_re, key_we, st_re, st_we;
    logic [IW-1:0]     key_raddr;
    logic [KEY_W-1:0]  key_rdata, key_item;
    logic [SW-1:0]     st_rdata;
    t_flow_state       old_st, upd_st;
    logic [32:0]       byte_sum;

    assign key_item = {i_q_item.addr_key, i_q_item.port_key, i_q_item.proto};
    assign out_free = !r_out_valid || i_pop;
    assign key_raddr = r_rd_idx[IW-1:0];

    pft_ram #(.WIDTH(KEY_W), .DEPTH(FLOW_ENTRIES)) u_key_ram (
        .i_clk  (i_clk),
        .i_we   (key_we),
        .i_waddr(r_slot),
        .i_wdata(key_item),
        .i_re   (key_re),
        .i_raddr(key_raddr),
        .o_rdata(key_rdata)
    );

    pft_ram #(.WIDTH(SW), .DEPTH(FLOW_ENTRIES)) u_state_ram (
        .i_clk  (i_clk),
        .i_we   (st_we),
        .i_waddr(r_slot),
        .i_wdata(upd_st),
        .i_re   (st_re),
        .i_raddr(r_slot),
        .o_rdata(st_rdata)
    );

    // per-flow update from the stored state, or a fresh one on creation
    always_comb begin
        if (r_new) begin
            old_st            = '0;
            old_st.svc_on_src = i_q_item.svc_on_src;
            old_st.svc        = i_q_item.svc;
        end else begin
            old_st = t_flow_state'(st_rdata);
        end
        upd_st   = old_st;
        byte_sum = {1'b0, old_st.bytes} + {17'd0, i_q_item.payload};
        upd_st.bytes = byte_sum[32] ? '1 : byte_sum[31:0];
        if (i_q_item.pure_ack) begin
            if (old_st.acks == 16'd0) upd_st.first_ack = i_q_item.time_us;
            upd_st.last_ack = i_q_item.time_us;
            if (old_st.acks != 16'hFFFF) upd_st.acks = old_st.acks + 16'd1;
        end
        if ((i_q_item.payload != 16'd0) && (old_st.samples < i_sample_limit)) begin
            upd_st.samples = old_st.samples + 8'd1;
        end
    end

    // sequencer: linear key search, one entry per cycle, then update
    always_comb begin
        n_state     = r_state;
        n_rd_idx    = r_rd_idx;
        n_chk_valid = r_chk_valid;
        n_chk_idx   = r_chk_idx;
        n_slot      = r_slot;
        n_new       = r_new;
        n_full      = r_full;
        n_used      = r_used;
        n_out_valid = r_out_valid && !i_pop;
        n_accepted  = r_accepted;
        n_flow_slot = r_flow_slot;
        n_new_flow  = r_new_flow;
        n_table_full = r_table_full;
        n_payload   = r_payload;
        n_bytes     = r_bytes;
        n_samples   = r_samples;
        n_svc       = r_svc;
        n_svc_src   = r_svc_src;
        n_acks      = r_acks;
        n_span      = r_span;
        key_re  = 1'b0;
        key_we  = 1'b0;
        st_re   = 1'b0;
        st_we   = 1'b0;
        o_q_pop = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    if (!i_q_item.ipv4) begin
                        if (out_free) begin
                            n_out_valid  = 1'b1;
                            n_accepted   = 1'b0;
                            n_flow_slot  = '0;
                            n_new_flow   = 1'b0;
                            n_table_full = 1'b0;
                            n_payload    = '0;
                            n_bytes      = '0;
                            n_samples    = '0;
                            n_svc        = SVC_UNKNOWN;
                            n_svc_src    = 1'b0;
                            n_acks       = '0;
                            n_span       = '0;
                            o_q_pop      = 1'b1;
                        end
                    end else begin
                        n_state     = S_SEARCH;
                        n_rd_idx    = '0;
                        n_chk_valid = 1'b0;
                        n_new       = 1'b0;
                        n_full      = 1'b0;
                    end
                end
            end
            S_SEARCH: begin
                if (r_chk_valid && (key_rdata == key_item)) begin
                    n_slot  = r_chk_idx;
                    n_state = S_READ;
                end else if (!r_chk_valid && (r_rd_idx >= r_used)) begin
                    // searched every used entry without a match
                    if (r_used == USED_MAX) begin
                        n_full = 1'b1;
                    end else begin
                        n_new  = 1'b1;
                        n_slot = r_used[IW-1:0];
                    end
                    n_state = S_UPD;
                end else begin
                    if (r_rd_idx < r_used) begin
                        key_re      = 1'b1;
                        n_chk_valid = 1'b1;
                        n_chk_idx   = r_rd_idx[IW-1:0];
                        n_rd_idx    = r_rd_idx + 1'b1;
                    end else begin
                        n_chk_valid = 1'b0;
                    end
                end
            end
            S_READ: begin
                st_re   = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_accepted   = 1'b1;
                    n_payload    = i_q_item.payload;
                    n_table_full = r_full;
                    if (r_full) begin
                        n_flow_slot = '0;
                        n_new_flow  = 1'b0;
                        n_bytes     = '0;
                        n_samples   = '0;
                        n_svc       = SVC_UNKNOWN;
                        n_svc_src   = 1'b0;
                        n_acks      = '0;
                        n_span      = '0;
                    end else begin
                        st_we       = 1'b1;
                        key_we      = r_new;
                        n_flow_slot = 8'(r_slot);
                        n_new_flow  = r_new;
                        n_bytes     = upd_st.bytes;
                        n_samples   = upd_st.samples;
                        n_svc       = upd_st.svc;
                        n_svc_src   = upd_st.svc_on_src;
                        n_acks      = upd_st.acks;
                        n_span      = (upd_st.acks != 16'd0)
                                    ? upd_st.last_ack - upd_st.first_ack : '0;
                        if (r_new) n_used = r_used + 1'b1;
                    end
                    o_q_pop = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chk_valid <= 1'b0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chk_valid <= n_chk_valid;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx     <= n_rd_idx;
        r_chk_idx    <= n_chk_idx;
        r_slot       <= n_slot;
        r_new        <= n_new;
        r_full       <= n_full;
        r_accepted   <= n_accepted;
        r_flow_slot  <= n_flow_slot;
        r_new_flow   <= n_new_flow;
        r_table_full <= n_table_full;
        r_payload    <= n_payload;
        r_bytes      <= n_bytes;
        r_samples    <= n_samples;
        r_svc        <= n_svc;
        r_svc_src    <= n_svc_src;
        r_acks       <= n_acks;
        r_span       <= n_span;
    end

    assign o_empty             = !r_out_valid;
    assign o_accepted          = r_accepted;
    assign o_flow_slot         = r_flow_slot;
    assign o_new_flow          = r_new_flow;
    assign o_table_full        = r_table_full;
    assign o_payload_length    = r_payload;
    assign o_byte_total        = r_bytes;
    assign o_samples_held      = r_samples;
    assign o_service           = r_svc;
    assign o_service_on_source = r_svc_src;
    assign o_ack_count         = r_acks;
    assign o_ack_span_us       = r_span;
endmodule
`default_nettype wire

[rtl/packet_flow_tracker_top.sv]
// packet_flow_tracker_top: five-tuple flow table, top level.
// Depends on pft_pkg, pft_front, pft_back (and pft_ram through pft_back).
//
// Usage:
//  - Headers enter as beats on a queue-style port: a beat is taken at a
//    rising edge with i_push high and o_full low. A two-entry queue sits
//    between the classifier and the table engine.
//  - Results leave the same way: the oldest result is on the o_ ports while
//    o_empty is low and is taken at an edge with i_pop high.
//  - The sample limit is written through i_cfg_valid / o_cfg_ready /
//    i_cfg_data; o_cfg_ready is always high.
//  - For an IPv4 beat the table engine reads the key RAM one entry per cycle
//    for the linear match search, then reads (for a known flow) and writes
//    the per-flow state RAM; a full table writes nothing. A non-IPv4
//    beat skips the search.
//  - Reset (synchronous, active low) empties the queue and the result
//    register, forgets all flows and sets the sample limit to 100.
//    No clearing pass is needed; the table fill count marks valid entries.
//  - If the receiver stalls, the result is held; up to two beats, counting
//    the one in the table engine, are queued before o_full rises.
`timescale 1ns / 1ps
`default_nettype none
module packet_flow_tracker_top #(
    parameter int FLOW_ENTRIES = pft_pkg::FLOW_ENTRIES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [15:0] i_ether_type,
    input  wire logic [3:0]  i_ip_header_words,
    input  wire logic [15:0] i_ip_total_length,
    input  wire logic [7:0]  i_ip_protocol,
    input  wire logic [31:0] i_source_ip,
    input  wire logic [31:0] i_dest_ip,
    input  wire logic [15:0] i_source_port,
    input  wire logic [15:0] i_dest_port,
    input  wire logic [3:0]  i_tcp_header_words,
    input  wire logic [7:0]  i_tcp_flags,
    input  wire logic [47:0] i_time_us,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic             o_accepted,
    output logic [7:0]       o_flow_slot,
    output logic             o_new_flow,
    output logic             o_table_full,
    output logic [15:0]      o_payload_length,
    output logic [31:0]      o_byte_total,
    output logic [7:0]       o_samples_held,
    output logic [1:0]       o_service,
    output logic             o_service_on_source,
    output logic [15:0]      o_ack_count,
    output logic [47:0]      o_ack_span_us
);
    import pft_pkg::*;

    logic       q_valid;
    logic       q_pop;
    t_item      q_item;
    logic [7:0] sample_limit;

    pft_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_ether_type      (i_ether_type),
        .i_ip_header_words (i_ip_header_words),
        .i_ip_total_length (i_ip_total_length),
        .i_ip_protocol     (i_ip_protocol),
        .i_source_ip       (i_source_ip),
        .i_dest_ip         (i_dest_ip),
        .i_source_port     (i_source_port),
        .i_dest_port       (i_dest_port),
        .i_tcp_header_words(i_tcp_header_words),
        .i_tcp_flags       (i_tcp_flags),
        .i_time_us         (i_time_us),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_sample_limit    (sample_limit),
        .o_q_valid         (q_valid),
        .o_q_item          (q_item),
        .i_q_pop           (q_pop)
    );

    pft_back #(.FLOW_ENTRIES(FLOW_ENTRIES)) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_item           (q_item),
        .o_q_pop            (q_pop),
        .i_sample_limit     (sample_limit),
        .o_empty            (o_empty),
        .i_pop              (i_pop),
        .o_accepted         (o_accepted),
        .o_flow_slot        (o_flow_slot),
        .o_new_flow         (o_new_flow),
        .o_table_full       (o_table_full),
        .o_payload_length   (o_payload_length),
        .o_byte_total       (o_byte_total),
        .o_samples_held     (o_samples_held),
        .o_service          (o_service),
        .o_service_on_source(o_service_on_source),
        .o_ack_count        (o_ack_count),
        .o_ack_span_us      (o_ack_span_us)
    );
endmodule
`default_nettype wire

[rtl/pft_checker.sv]
// pft_checker: port-level checks on the flow tracker result stream,
// bound to packet_flow_tracker_top. No package dependency.
`timescale 1ns / 1ps
`default_nettype none
module pft_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_empty,
    input wire logic        i_pop,
    input wire logic        o_accepted,
    input wire logic [7:0]  o_flow_slot,
    input wire logic        o_new_flow,
    input wire logic        o_table_full,
    input wire logic [15:0] o_payload_length,
    input wire logic [31:0] o_byte_total,
    input wire logic [7:0]  o_samples_held,
    input wire logic [15:0] o_ack_count,
    input wire logic [47:0] o_ack_span_us
);
    // no result is shown right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_empty)
        else $error("result shown right after reset");

    // a waiting result beat holds still while the receiver stalls
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=>
        (!o_empty && $stable(o_accepted) && $stable(o_flow_slot)
         && $stable(o_payload_length) && $stable(o_byte_total)
         && $stable(o_ack_span_us)))
        else $error("waiting result changed during a stall");

    // a non-IPv4 beat gives an all-zero result
    a_ignored_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_accepted) |->
        (o_flow_slot == 8'd0 && o_payload_length == 16'd0 && o_byte_total == 32'd0
         && !o_new_flow && !o_table_full && o_ack_count == 16'd0))
        else $error("ignored beat with nonzero fields");

    // a full table stores nothing
    a_full_no_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_table_full) |->
        (!o_new_flow && o_byte_total == 32'd0 && o_ack_count == 16'd0))
        else $error("table full result carries flow data");

    // a fresh flow has seen at most this one packet
    a_new_flow_fresh: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_new_flow) |->
        (o_samples_held <= 8'd1 && o_ack_count <= 16'd1 && o_ack_span_us == 48'd0
         && o_byte_total == {16'd0, o_payload_length}))
        else $error("new flow with history");
endmodule

bind packet_flow_tracker_top pft_checker u_pft_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_empty         (o_empty),
    .i_pop           (i_pop),
    .o_accepted      (o_accepted),
    .o_flow_slot     (o_flow_slot),
    .o_new_flow      (o_new_flow),
    .o_table_full    (o_table_full),
    .o_payload_length(o_payload_length),
    .o_byte_total    (o_byte_total),
    .o_samples_held  (o_samples_held),
    .o_ack_count     (o_ack_count),
    .o_ack_span_us   (o_ack_span_us)
);
`default_nettype wire

[test/tb_flow_table_checker.sv]
// tb_flow_table_checker: watches the header, result and config channels of
// packet_flow_tracker_top, predicts every result and compares it.
// Depends on pft_pkg for the protocol, port and service constants.
`timescale 1ns / 1ps
module tb_flow_table_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [15:0] i_ether_type,
    input  logic [3:0]  i_ip_header_words,
    input  logic [15:0] i_ip_total_length,
    input  logic [7:0]  i_ip_protocol,
    input  logic [31:0] i_source_ip,
    input  logic [31:0] i_dest_ip,
    input  logic [15:0] i_source_port,
    input  logic [15:0] i_dest_port,
    input  logic [3:0]  i_tcp_header_words,
    input  logic [7:0]  i_tcp_flags,
    input  logic [47:0] i_time_us,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [7:0]  i_cfg_data,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_accepted,
    input  logic [7:0]  i_flow_slot,
    input  logic        i_new_flow,
    input  logic        i_table_full,
    input  logic [15:0] i_payload_length,
    input  logic [31:0] i_byte_total,
    input  logic [7:0]  i_samples_held,
    input  logic [1:0]  i_service,
    input  logic        i_service_on_source,
    input  logic [15:0] i_ack_count,
    input  logic [47:0] i_ack_span_us,
    output int          o_errors,
    output int          o_pending,
    output int          o_results,
    output int          o_full_hits
);
    import pft_pkg::*;

    localparam int ENTRIES = FLOW_ENTRIES_DEF;

    typedef struct {
        logic        accepted;
        logic [7:0]  slot;
        logic        new_flow;
        logic        table_full;
        logic [15:0] payload;
        logic [31:0] bytes;
        logic [7:0]  samples;
        logic [1:0]  svc;
        logic        svc_on_src;
        logic [15:0] acks;
        logic [47:0] span;
    } t_flow_result;

    // shadow flow table
    logic [63:0] tbl_addr [ENTRIES];
    logic [31:0] tbl_ports [ENTRIES];
    logic [7:0]  tbl_proto [ENTRIES];
    logic [31:0] tbl_bytes [ENTRIES];
    logic [7:0]  tbl_samples [ENTRIES];
    logic [1:0]  tbl_svc [ENTRIES];
    logic        tbl_svc_src [ENTRIES];
    logic [15:0] tbl_acks [ENTRIES];
    logic [47:0] tbl_first [ENTRIES];
    logic [47:0] tbl_last [ENTRIES];
    int          flows_used;
    logic [7:0]  sample_cap;

    t_flow_result expected_results[$];

    assign o_pending = expected_results.size();

    function automatic logic port_is_http(input logic [15:0] p);
        return p == PORT_HTTP || p == PORT_HTTP_ALT1 || p == PORT_HTTP_ALT2 ||
               p == PORT_HTTP_ALT3;
    endfunction

    // work out the result of one header and update the shadow table
    task automatic track_header(output t_flow_result r);
        logic [15:0] l4;
        logic [63:0] akey;
        logic [31:0] pkey;
        logic [32:0] sum;
        int s;
        r = '{default: '0};
        akey = {i_source_ip, i_dest_ip};
        pkey = {i_source_port, i_dest_port};
        s = -1;
        if (i_ether_type != ETH_IPV4) return;
        r.accepted = 1'b1;
        l4 = (i_ip_protocol == PROTO_UDP) ? UDP_HDR_BYTES : {10'd0, i_tcp_header_words, 2'b00};
        r.payload = i_ip_total_length - {10'd0, i_ip_header_words, 2'b00} - l4;
        for (int i = 0; i < flows_used; i++) begin
            if (s < 0 && tbl_addr[i] == akey && tbl_ports[i] == pkey &&
                tbl_proto[i] == i_ip_protocol) s = i;
        end
        if (s >= 0) begin
            sum = {1'b0, tbl_bytes[s]} + {17'd0, r.payload};
            tbl_bytes[s] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end else begin
            if (flows_used >= ENTRIES) begin
                r.table_full = 1'b1;
                return;
            end
            s = flows_used;
            flows_used++;
            r.new_flow = 1'b1;
            tbl_addr[s] = akey;
            tbl_ports[s] = pkey;
            tbl_proto[s] = i_ip_protocol;
            tbl_bytes[s] = {16'd0, r.payload};
            tbl_samples[s] = '0;
            tbl_acks[s] = '0;
            tbl_first[s] = '0;
            tbl_last[s] = '0;
            // destination before source, http then mysql then memcached
            tbl_svc_src[s] = 1'b0;
            if (port_is_http(i_dest_port)) tbl_svc[s] = SVC_HTTP;
            else if (port_is_http(i_source_port)) begin
                tbl_svc[s] = SVC_HTTP; tbl_svc_src[s] = 1'b1;
            end else if (i_dest_port == PORT_MYSQL) tbl_svc[s] = SVC_MYSQL;
            else if (i_source_port == PORT_MYSQL) begin
                tbl_svc[s] = SVC_MYSQL; tbl_svc_src[s] = 1'b1;
            end else if (i_dest_port == PORT_MEMCACHED) tbl_svc[s] = SVC_MEMCACHED;
            else if (i_source_port == PORT_MEMCACHED) begin
                tbl_svc[s] = SVC_MEMCACHED; tbl_svc_src[s] = 1'b1;
            end else tbl_svc[s] = SVC_UNKNOWN;
        end
        // pure ACK timing, count saturates but last time keeps moving
        if (i_ip_protocol != PROTO_UDP && i_tcp_flags == FLAGS_PURE_ACK) begin
            if (tbl_acks[s] == 16'd0) tbl_first[s] = i_time_us;
            tbl_last[s] = i_time_us;
            if (tbl_acks[s] != 16'hFFFF) tbl_acks[s]++;
        end
        if (r.payload != 16'd0 && tbl_samples[s] < sample_cap) tbl_samples[s]++;
        r.slot = s[7:0];
        r.bytes = tbl_bytes[s];
        r.samples = tbl_samples[s];
        r.svc = tbl_svc[s];
        r.svc_on_src = tbl_svc_src[s];
        r.acks = tbl_acks[s];
        r.span = (tbl_acks[s] != 16'd0) ? tbl_last[s] - tbl_first[s] : '0;
    endtask

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("%0t: result %0d %s got %0h want %0h", $realtime, o_results, what, got, want);
        o_errors++;
    endtask

    task automatic compare_field(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        if (got !== want) report(what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_flow_result r;
        if (!i_rst_n) begin
            flows_used = 0;
            sample_cap = SAMPLE_LIMIT_RST;
            o_errors = 0;
            o_results = 0;
            o_full_hits = 0;
            expected_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) sample_cap = i_cfg_data;
            if (i_push && !i_full) begin
                track_header(r);
                if (r.table_full) o_full_hits++;
                expected_results.insert(expected_results.size(), r);
            end
            // compare one result beat with the oldest prediction
            if (i_pop && !i_empty) begin
                if (expected_results.size() == 0) begin
                    report("unexpected", '0, '0);
                end else begin
                    r = expected_results.pop_front();
                    compare_field("accepted", 64'(i_accepted), 64'(r.accepted));
                    compare_field("flow_slot", 64'(i_flow_slot), 64'(r.slot));
                    compare_field("new_flow", 64'(i_new_flow), 64'(r.new_flow));
                    compare_field("table_full", 64'(i_table_full), 64'(r.table_full));
                    compare_field("payload_length", 64'(i_payload_length), 64'(r.payload));
                    compare_field("byte_total", 64'(i_byte_total), 64'(r.bytes));
                    compare_field("samples_held", 64'(i_samples_held), 64'(r.samples));
                    compare_field("service", 64'(i_service), 64'(r.svc));
                    compare_field("service_on_source", 64'(i_service_on_source),
                                  64'(r.svc_on_src));
                    compare_field("ack_count", 64'(i_ack_count), 64'(r.acks));
                    compare_field("ack_span_us", 64'(i_ack_span_us), 64'(r.span));
                end
                o_results++;
            end
        end
    end

endmodule

[test/tb_packet_flow_tracker_top.sv]
// tb_packet_flow_tracker_top: drives headers and sample-limit writes into
// packet_flow_tracker_top with random gaps and stalls; tb_flow_table_checker judges.
// Depends on pft_pkg, the RTL and tb_flow_table_checker.
`timescale 1ns / 1ps
module tb_packet_flow_tracker_top;
    import pft_pkg::*;

    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam int POOL = 24;

    logic        i_clk, i_rst_n, i_push, i_pop, i_cfg_valid;
    logic [15:0] i_ether_type, i_ip_total_length, i_source_port, i_dest_port;
    logic [3:0]  i_ip_header_words, i_tcp_header_words;
    logic [7:0]  i_ip_protocol, i_tcp_flags, i_cfg_data;
    logic [31:0] i_source_ip, i_dest_ip;
    logic [47:0] i_time_us;
    logic        o_full, o_cfg_ready, o_empty, o_accepted, o_new_flow, o_table_full;
    logic        o_service_on_source;
    logic [7:0]  o_flow_slot, o_samples_held;
    logic [15:0] o_payload_length, o_ack_count;
    logic [31:0] o_byte_total;
    logic [1:0]  o_service;
    logic [47:0] o_ack_span_us;

    int errors, pending, results, full_hits, headers_sent, limits_set;
    bit steady;     // no gaps on either side while set

    logic [31:0] pool_sip [POOL], pool_dip [POOL];
    logic [15:0] pool_sp [POOL], pool_dp [POOL];
    logic [7:0]  pool_proto [POOL];

    packet_flow_tracker_top DUT (.*);

    tb_flow_table_checker checker_i (
        .i_clk, .i_rst_n, .i_push, .i_full(o_full), .i_ether_type, .i_ip_header_words,
        .i_ip_total_length, .i_ip_protocol, .i_source_ip, .i_dest_ip, .i_source_port,
        .i_dest_port, .i_tcp_header_words, .i_tcp_flags, .i_time_us, .i_cfg_valid,
        .i_cfg_ready(o_cfg_ready), .i_cfg_data, .i_empty(o_empty), .i_pop,
        .i_accepted(o_accepted), .i_flow_slot(o_flow_slot), .i_new_flow(o_new_flow),
        .i_table_full(o_table_full), .i_payload_length(o_payload_length),
        .i_byte_total(o_byte_total), .i_samples_held(o_samples_held),
        .i_service(o_service), .i_service_on_source(o_service_on_source),
        .i_ack_count(o_ack_count), .i_ack_span_us(o_ack_span_us),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_full_hits(full_hits)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // result side: random stalls on pop
    initial begin
        int n;
        i_pop = 1'b0;
        forever begin
            @(posedge i_clk);
            n = gap_len();
            if (n > 0) begin
                i_pop <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            i_pop <= 1'b1;
        end
    end

    // one header beat; push stays high when the next beat follows at once
    task automatic send(input logic [15:0] et, input logic [3:0] ihw, input logic [15:0] tl,
                        input logic [7:0] proto, input logic [31:0] sip, input logic [31:0] dip,
                        input logic [15:0] sp, input logic [15:0] dp, input logic [3:0] thw,
                        input logic [7:0] flags, input logic [47:0] t);
        int n;
        n = gap_len();
        if (n > 0) begin
            i_push <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_ether_type <= et;
        i_ip_header_words <= ihw;
        i_ip_total_length <= tl;
        i_ip_protocol <= proto;
        i_source_ip <= sip;
        i_dest_ip <= dip;
        i_source_port <= sp;
        i_dest_port <= dp;
        i_tcp_header_words <= thw;
        i_tcp_flags <= flags;
        i_time_us <= t;
        do @(negedge i_clk); while (o_full);
        @(posedge i_clk);
        headers_sent++;
    endtask

    // let the block drain, then write the sample limit
    task automatic set_sample_limit(input logic [7:0] lim);
        i_push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= lim;
        do @(negedge i_clk); while (!o_cfg_ready);
        @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        limits_set++;
    endtask

    function automatic logic [15:0] pick_port();
        case ($urandom_range(0, 9))
            0: return PORT_HTTP;
            1: return PORT_HTTP_ALT1;
            2: return PORT_HTTP_ALT2;
            3: return PORT_HTTP_ALT3;
            4: return PORT_MYSQL;
            5: return PORT_MEMCACHED;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [7:0] pick_proto();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return PROTO_UDP;
        if (r < 9) return PROTO_TCP;
        return 8'($urandom_range(0, 255));
    endfunction

    // kind: 0 known flow, 1 fresh flow, 2 raw noise
    task automatic random_header(input int kind);
        logic [31:0] sip, dip;
        logic [15:0] sp, dp, tl, et;
        logic [7:0]  proto, flags;
        logic [3:0]  ihw, thw;
        int k;
        k = $urandom_range(0, POOL - 1);
        sip = pool_sip[k]; dip = pool_dip[k]; sp = pool_sp[k]; dp = pool_dp[k];
        proto = pool_proto[k];
        if (kind != 0) begin
            sip = $urandom; dip = $urandom; sp = pick_port(); dp = pick_port();
            proto = pick_proto();
        end
        et = (kind == 2 && $urandom_range(0, 1)) ? 16'($urandom) : ETH_IPV4;
        ihw = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
        thw = ($urandom_range(0, 4) == 0) ? 4'($urandom) : 4'd5;
        tl = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(20, 1500));
        flags = ($urandom_range(0, 9) < 4) ? FLAGS_PURE_ACK : 8'($urandom);
        send(et, ihw, tl, proto, sip, dip, sp, dp, thw, flags, 48'({$urandom, $urandom}));
    endtask

    // stimulus
    initial begin
        i_rst_n = 1'b0; i_push = 1'b0; i_cfg_valid = 1'b0; i_cfg_data = '0;
        i_ether_type = '0; i_ip_header_words = '0; i_ip_total_length = '0;
        i_ip_protocol = '0; i_source_ip = '0; i_dest_ip = '0; i_source_port = '0;
        i_dest_port = '0; i_tcp_header_words = '0; i_tcp_flags = '0; i_time_us = '0;
        headers_sent = 0; limits_set = 0; steady = 1'b0;
        for (int k = 0; k < POOL; k++) begin
            pool_sip[k] = $urandom; pool_dip[k] = $urandom;
            pool_sp[k] = pick_port(); pool_dp[k] = pick_port(); pool_proto[k] = pick_proto();
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed headers at a small sample limit
        set_sample_limit(8'd2);
        send(16'h86DD, 4'hF, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
             16'hFFFF, 4'hF, 8'hFF, 48'hFFFF_FFFF_FFFF);
        send(16'h0000, 4'd5, 16'd100, PROTO_UDP, 32'd1, 32'd2, 16'd1, 16'd2, 4'd5,
             FLAGS_PURE_ACK, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd100, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0002, 16'd5000,
             PORT_HTTP, 4'd5, FLAGS_PURE_ACK, 48'd1);
        send(ETH_IPV4, 4'd5, 16'd200, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0002, 16'd5000,
             PORT_HTTP, 4'd0, 8'h00, 48'd2);
        send(ETH_IPV4, 4'd5, 16'd300, PROTO_UDP, 32'h0A00_0001, 32'h0A00_0002, 16'd5000,
             PORT_HTTP, 4'd0, 8'h00, 48'd3);
        send(ETH_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0, 32'h0, PORT_HTTP_ALT1, 16'd0,
             4'd5, FLAGS_PURE_ACK, 48'd5);
        // ACK time going backwards wraps the span
        send(ETH_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'h0, 32'h0, PORT_HTTP_ALT1, 16'd0,
             4'd5, FLAGS_PURE_ACK, 48'd3);
        send(ETH_IPV4, 4'd5, 16'd90, PROTO_TCP, 32'h0, 32'h0, PORT_HTTP_ALT1, 16'd0,
             4'd5, 8'h11, 48'd9);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_TCP, 32'd7, 32'd8, 16'd1, PORT_HTTP_ALT2,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_TCP, 32'd7, 32'd8, PORT_HTTP_ALT3, PORT_MYSQL,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_TCP, 32'd7, 32'd8, PORT_MYSQL, PORT_MEMCACHED,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_TCP, 32'd7, 32'd8, PORT_MEMCACHED, PORT_MYSQL,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_UDP, 32'd7, 32'd8, 16'd9, PORT_MEMCACHED,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, PROTO_UDP, 32'd7, 32'd8, PORT_MEMCACHED, 16'd9,
             4'd5, 8'h00, 48'd0);
        send(ETH_IPV4, 4'd5, 16'd60, 8'd0, 32'd7, 32'd8, 16'd0, 16'hFFFF,
             4'd5, 8'h00, 48'd0);
        // zero payload is not a sample
        send(ETH_IPV4, 4'd5, 16'd40, PROTO_TCP, 32'd7, 32'd8, 16'd0, 16'hFFFF,
             4'd5, FLAGS_PURE_ACK, 48'hFFFF_FFFF_FFFF);
        // header lengths larger than the packet wrap; then an IP header length of zero
        send(ETH_IPV4, 4'hF, 16'd0, 8'hFF, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0,
             4'hF, 8'h10, 48'd0);
        send(ETH_IPV4, 4'd0, 16'hFFFF, PROTO_UDP, 32'hFFFF_FFFF, 32'h0, 16'hFFFF, 16'h0,
             4'hF, FLAGS_PURE_ACK, 48'd7);
        // same tuple, different protocol is another flow
        send(ETH_IPV4, 4'd5, 16'd100, PROTO_TCP, 32'h0A00_0001, 32'h0A00_0002, 16'd5000,
             PORT_HTTP, 4'd5, 8'h00, 48'd1);

        // random traffic over known flows, then the table fills up
        set_sample_limit(8'd0);
        for (int n = 0; n < 300; n++) random_header($urandom_range(0, 9) < 8 ? 0 : 2);
        set_sample_limit(8'd255);
        steady = 1'b1;
        for (int n = 0; n < 150; n++) random_header(0);
        steady = 1'b0;
        for (int n = 0; n < 330; n++) random_header($urandom_range(0, 9) < 7 ? 1 : 0);
        set_sample_limit(8'($urandom_range(1, 254)));
        for (int n = 0; n < 650; n++) begin
            case ($urandom_range(0, 9))
                0, 1: random_header(1);
                2: random_header(2);
                default: random_header(0);
            endcase
        end

        // drain and allow for stragglers
        i_push <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Sent %0d headers over %0d sample-limit settings; %0d results checked,",
                 headers_sent, limits_set, results);
        $display("%0d of them rejected with the flow table full.", full_hits);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #60ms;
        $display("Timed out with %0d results outstanding", pending);
        $display("Mismatches found");
        $finish;
    end

endmodule

[filelist.f]
rtl/pft_pkg.sv
rtl/pft_ram.sv
rtl/pft_front.sv
rtl/pft_back.sv
rtl/packet_flow_tracker_top.sv
rtl/pft_checker.sv
test/tb_flow_table_checker.sv
test/tb_packet_flow_tracker_top.sv
